// ----- rtl/qamhd_pkg.sv -----
// Package for the QAM hard-decision demapper: modulation order codes,
// configuration register indexes and the slicer decision thresholds.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package qamhd_pkg;

  // Modulation order; bits per axis is the code plus one
  typedef enum logic [1:0] {
    MOD_QPSK   = 2'd0,
    MOD_QAM16  = 2'd1,
    MOD_QAM64  = 2'd2,
    MOD_QAM256 = 2'd3
  } mod_order_t;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_MOD_ORDER     = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LLR_MAGNITUDE = 1'd1;

  // Widest register and the widest symbol in bits
  localparam int CFG_DATA_W = 7;
  localparam int BITS_MAX   = 8;
  localparam int AXIS_BITS  = 4;
  localparam int LEVELS_MAX = 16;

  // Threshold width: largest magnitude is 14 * 314, held signed
  localparam int THR_W = 14;

  // Decision boundary between level j-1 and level j, in Q1.12.
  // Scales are round(4096 / sqrt(k)) for k = 2, 10, 42, 170.
  function automatic logic signed [THR_W-1:0] slice_threshold(mod_order_t ord,
                                                              logic [3:0] j);
    int s;
    int l;
    case (ord)
      MOD_QPSK:   begin s = 2896; l = 2;  end
      MOD_QAM16:  begin s = 1295; l = 4;  end
      MOD_QAM64:  begin s = 632;  l = 8;  end
      MOD_QAM256: begin s = 314;  l = 16; end
      default:    begin s = 2896; l = 2;  end
    endcase
    return THR_W'((2 * int'(j) - l) * s);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/qam_hard_decision_demapper.sv -----
// QAM hard-decision demapper top level: input register, threshold slicer,
// bit serialiser and registered result outputs.
// Depends on qamhd_pkg.
`timescale 1ns / 1ps
`default_nettype none

// The first result beat of a symbol passes the input register, the serialiser and the
//   output register when the serialiser is free, else it follows the previous symbol's last beat.
// One result beat per cycle; a symbol gives 2*(mod_order+1) beats
//   (2 for QPSK up to 8 for 256QAM), set by the single-bit serialiser.
// A new symbol is taken while the previous one is still being serialised.
// Reset clears control state and sets mod_order to QPSK and llr_magnitude
//   to 64; results cannot be stalled by the receiver.
module qam_hard_decision_demapper #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int LLR_WIDTH    = 8
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // symbol command
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic signed [SAMPLE_WIDTH-1:0]       sym_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0]       sym_q,
  // configuration write port
  input  wire logic                                 cfg_we,
  input  wire logic [qamhd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [qamhd_pkg::CFG_DATA_W-1:0]     cfg_data,
  // result beats
  output logic                                      strobe,
  output logic signed [LLR_WIDTH-1:0]               soft_value,
  output logic                                      hard_bit,
  output logic [2:0]                                bit_index,
  output logic                                      last_bit
);

  import qamhd_pkg::*;

  localparam int CMP_W   = (SAMPLE_WIDTH > THR_W) ? SAMPLE_WIDTH : THR_W;
  localparam int MAG_MAX = (1 << (LLR_WIDTH - 1)) - 1;

  // Configuration registers
  mod_order_t      mod_order;
  logic [6:0]      llr_magnitude;

  // Input register
  logic                           in_valid;
  logic signed [SAMPLE_WIDTH-1:0] in_i;
  logic signed [SAMPLE_WIDTH-1:0] in_q;

  // Serialiser
  logic                  ser_active;
  logic [BITS_MAX-1:0]   ser_word;
  logic [2:0]            ser_index;
  logic [2:0]            ser_last;
  logic                  ser_free;
  logic                  ser_load;
  logic                  accept;

  // Slicer
  logic signed [CMP_W-1:0]   x_i;
  logic signed [CMP_W-1:0]   x_q;
  logic [LEVELS_MAX-1:1]     above_i;
  logic [LEVELS_MAX-1:1]     above_q;
  logic [AXIS_BITS-1:0]      lvl_i;
  logic [AXIS_BITS-1:0]      lvl_q;
  logic [2:0]                half;
  logic [BITS_MAX-1:0]       both;
  logic [BITS_MAX-1:0]       slice_word;
  logic [2:0]                slice_last;
  logic [LLR_WIDTH-1:0]      mag_sat;

  // Handshake
  assign ser_free = !ser_active || (ser_index == ser_last);
  assign ser_load = in_valid && ser_free;
  assign busy     = in_valid && !ser_free;
  assign accept   = start && !busy;

  // Compare each axis against every decision boundary of the order
  assign x_i = CMP_W'(in_i);
  assign x_q = CMP_W'(in_q);

  for (genvar j = 1; j < LEVELS_MAX; j++) begin : g_thr
    logic signed [CMP_W-1:0] thr;
    logic                    thr_en;
    assign thr       = CMP_W'(slice_threshold(mod_order, 4'(j)));
    assign thr_en    = 5'(j) < (5'd2 << mod_order);
    assign above_i[j] = thr_en && (x_i > thr);
    assign above_q[j] = thr_en && (x_q > thr);
  end

  // Level number is the count of boundaries passed; ties stay low
  always_comb begin
    lvl_i = '0;
    lvl_q = '0;
    for (int j = 1; j < LEVELS_MAX; j++) begin
      lvl_i = lvl_i + AXIS_BITS'(above_i[j]);
      lvl_q = lvl_q + AXIS_BITS'(above_q[j]);
    end
  end

  // Pack I bits before Q bits and left-align for MSB-first shifting
  assign half       = 3'(mod_order) + 3'd1;
  assign both       = ({4'b0, lvl_i} << half) | {4'b0, lvl_q};
  assign slice_word = both << (3'd6 - {mod_order, 1'b0});
  assign slice_last = {mod_order, 1'b1};

  // Saturate the magnitude to the LLR width
  always_comb begin
    if (32'(llr_magnitude) > 32'(MAG_MAX)) begin
      mag_sat = LLR_WIDTH'(MAG_MAX);
    end else begin
      mag_sat = LLR_WIDTH'(llr_magnitude);
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mod_order     <= MOD_QPSK;
      llr_magnitude <= 7'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MOD_ORDER:     mod_order     <= mod_order_t'(cfg_data[1:0]);
        REG_LLR_MAGNITUDE: llr_magnitude <= cfg_data[6:0];
        default:           ;
      endcase
    end
  end

  // Hold the accepted symbol until the serialiser takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (accept) begin
      in_valid <= 1'b1;
    end else if (ser_load) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_i <= sym_i;
      in_q <= sym_q;
    end
  end

  // Load the sliced word, or advance one bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      ser_active <= 1'b0;
    end else if (ser_load) begin
      ser_active <= 1'b1;
    end else if (ser_free) begin
      ser_active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ser_load) begin
      ser_word  <= slice_word;
      ser_index <= 3'd0;
      ser_last  <= slice_last;
    end else if (ser_active) begin
      ser_word  <= ser_word << 1;
      ser_index <= ser_index + 3'd1;
    end
  end

  // Register the result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= ser_active;
    end
  end

  always_ff @(posedge clk) begin
    hard_bit   <= ser_word[BITS_MAX-1];
    soft_value <= ser_word[BITS_MAX-1] ? -mag_sat : mag_sat;
    bit_index  <= ser_index;
    last_bit   <= (ser_index == ser_last);
  end

  // Bits of one symbol leave on consecutive cycles
  assert property (@(posedge clk) disable iff (rst)
    strobe && !last_bit |=> strobe && (bit_index == $past(bit_index) + 3'd1))
    else $error("symbol bits not consecutive");

  // A symbol always carries an even number of bits
  assert property (@(posedge clk) disable iff (rst)
    strobe && last_bit |-> bit_index[0])
    else $error("last bit at even index");

  // A beat past the first one always follows another beat
  assert property (@(posedge clk) disable iff (rst)
    strobe && (bit_index != 3'd0) |-> $past(strobe))
    else $error("symbol resumed after a gap");

  // Nothing leaves in the cycle after reset
  assert property (@(posedge clk)
    rst |=> !strobe)
    else $error("beat strobed after reset");

endmodule

`default_nettype wire
